/* design/fir_ldc_pkg.sv */
package fir_ldc_pkg;

  // Filter geometry and number formats.
  localparam int TAP_COUNT   = 51;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int DC_BITS     = 16;

  // The coefficient table holds one half of a symmetric 51-tap low-pass in Q15.
  localparam int ROM_TAPS = 51;
  localparam int ROM_HALF = 26;
  localparam int ROM_BITS = 16;
  localparam int ROM_IDX_BITS = $clog2(ROM_HALF);

  localparam int COEF_FRAC     = COEF_BITS - 1;
  localparam int COEF_SHIFT_UP = (COEF_BITS >= ROM_BITS) ? (COEF_BITS - ROM_BITS) : 0;
  localparam int COEF_SHIFT_DN = (COEF_BITS < ROM_BITS) ? (ROM_BITS - COEF_BITS) : 0;
  localparam int COEF_ROUND    = (COEF_SHIFT_DN > 0) ? (1 << (COEF_SHIFT_DN - 1)) : 0;

  localparam int TAP_IDX_BITS = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS + 1;
  localparam int ACC_BITS     = PROD_BITS + TAP_IDX_BITS;

  localparam logic [ROM_BITS-1:0] HALF_ROM [ROM_HALF] = '{
    16'd0,    16'd5,    16'd13,   16'd23,   16'd39,   16'd61,   16'd91,
    16'd131,  16'd180,  16'd240,  16'd312,  16'd393,  16'd485,  16'd585,
    16'd691,  16'd801,  16'd914,  16'd1025, 16'd1133, 16'd1234, 16'd1325,
    16'd1403, 16'd1467, 16'd1514, 16'd1543, 16'd1552
  };

  // One word on the input side.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ac_red;
    logic        [DC_BITS-1:0]     dc_red;
    logic signed [SAMPLE_BITS-1:0] ac_ir;
    logic        [DC_BITS-1:0]     dc_ir;
  } sample_word_t;

  // One word on the output side.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_ac_red;
    logic        [DC_BITS-1:0]     passed_dc_red;
    logic signed [SAMPLE_BITS-1:0] filtered_ac_ir;
    logic        [DC_BITS-1:0]     passed_dc_ir;
  } result_word_t;

  // The pair of AC samples held by one delay cell.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] red;
    logic signed [SAMPLE_BITS-1:0] ir;
  } tap_pair_t;

  // Control from the sequencer to the multiply-accumulate units.
  typedef struct packed {
    logic clear;
    logic step;
  } mac_ctrl_t;

  // Coefficient for tap k, mirrored from the half table and scaled to COEF_BITS.
  function automatic logic [COEF_BITS-1:0] coef(input logic [TAP_IDX_BITS-1:0] k);
    logic [COEF_BITS+ROM_BITS-1:0] wide;
    logic [ROM_IDX_BITS-1:0]       idx;
    wide = '0;
    if (int'(k) < ROM_TAPS) begin
      idx  = (int'(k) < ROM_HALF) ? ROM_IDX_BITS'(k)
                                  : ROM_IDX_BITS'(ROM_TAPS - 1 - int'(k));
      wide = {{COEF_BITS{1'b0}}, HALF_ROM[idx]};
      if (COEF_BITS >= ROM_BITS) begin
        wide = wide << COEF_SHIFT_UP;
      end else begin
        wide = (wide + (COEF_BITS+ROM_BITS)'(COEF_ROUND)) >> COEF_SHIFT_DN;
      end
    end
    return wide[COEF_BITS-1:0];
  endfunction

endpackage

/* design/fir_ldc_cell.sv */
module fir_ldc_cell import fir_ldc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  tap_pair_t prev,
  output tap_pair_t value
);

  // One delay slot for both channels; it takes its neighbor's pair on a shift.
  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
    end else if (shift) begin
      value <= prev;
    end
  end

endmodule

/* design/fir_ldc_mac.sv */
module fir_ldc_mac import fir_ldc_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_ctrl_t                     ctrl,
  input  logic signed [SAMPLE_BITS-1:0] tap_sample,
  input  logic        [COEF_BITS-1:0]   tap_coef,
  output logic signed [SAMPLE_BITS-1:0] filtered
);

  localparam logic signed [ACC_BITS:0] SAT_MAX = (ACC_BITS+1)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS:0] SAT_MIN = -SAT_MAX - 1;
  localparam logic signed [ACC_BITS:0] HALF_LSB = (ACC_BITS+1)'(1 << (COEF_FRAC - 1));

  logic signed [PROD_BITS-1:0] prod;
  logic                        prod_valid;
  logic signed [ACC_BITS-1:0]  acc;
  logic signed [ACC_BITS:0]    rounded;
  logic signed [ACC_BITS:0]    scaled;

  // Registered product of the current tap, accumulated in the following cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctrl.step;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(tap_sample * $signed({1'b0, tap_coef}));
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + ACC_BITS'(prod);
    end
  end

  // Round half up, drop the coefficient fraction, and saturate to the sample range.
  always_comb begin
    rounded = (ACC_BITS+1)'(acc) + HALF_LSB;
    scaled  = rounded >>> COEF_FRAC;
    if (scaled > SAT_MAX) begin
      filtered = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_MIN) begin
      filtered = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      filtered = scaled[SAMPLE_BITS-1:0];
    end
  end

endmodule

/* design/fir_lowpass_dual_channel_unit.sv */
// After a sample word is accepted, the unit runs its taps, drains and rounds, then loads the result word.
// A new word is taken only in idle; a single multiply-accumulate per channel
// visits the 51 taps one per cycle while the delay ring rotates once around.
// A finished result waits in the output register while the next word is taken.
// Reset clears both delay lines to zero and returns the control to idle.
module fir_lowpass_dual_channel_unit import fir_ldc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         sample_valid,
  output logic         sample_ready,
  input  sample_word_t sample,
  output logic         result_valid,
  input  logic         result_ready,
  output result_word_t result
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_ROUND} state_t;

  state_t                        state;
  logic [TAP_IDX_BITS-1:0]       tap_idx;
  logic [DC_BITS-1:0]            dc_red;
  logic [DC_BITS-1:0]            dc_ir;
  tap_pair_t                     ring [TAP_COUNT];
  tap_pair_t                     ring_head_in;
  logic                          ring_shift;
  logic                          accept;
  logic                          load_result;
  mac_ctrl_t                     mac_ctrl;
  logic [COEF_BITS-1:0]          coef_now;
  logic signed [SAMPLE_BITS-1:0] red_y;
  logic signed [SAMPLE_BITS-1:0] ir_y;

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign load_result  = (state == ST_ROUND) && (!result_valid || result_ready);

  // The ring shifts in the new pair on accept, then rotates once per tap.
  assign ring_shift   = accept || (state == ST_RUN);
  assign ring_head_in = accept ? tap_pair_t'{red: sample.ac_red, ir: sample.ac_ir}
                               : ring[TAP_COUNT-1];

  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    if (i == 0) begin : g_head
      fir_ldc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring_shift),
        .prev  (ring_head_in),
        .value (ring[i])
      );
    end else begin : g_body
      fir_ldc_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (ring_shift),
        .prev  (ring[i-1]),
        .value (ring[i])
      );
    end
  end

  // The head cell holds the sample for tap_idx; taps run 0, then down from the top.
  assign coef_now       = coef(tap_idx);
  assign mac_ctrl.clear = accept;
  assign mac_ctrl.step  = (state == ST_RUN);

  fir_ldc_mac u_mac_red (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .tap_sample (ring[0].red),
    .tap_coef   (coef_now),
    .filtered   (red_y)
  );

  fir_ldc_mac u_mac_ir (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (mac_ctrl),
    .tap_sample (ring[0].ir),
    .tap_coef   (coef_now),
    .filtered   (ir_y)
  );

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tap_idx      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready && !load_result) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state   <= ST_RUN;
            tap_idx <= '0;
            dc_red  <= sample.dc_red;
            dc_ir   <= sample.dc_ir;
          end
        end
        ST_RUN: begin
          tap_idx <= (tap_idx == '0) ? TAP_IDX_BITS'(TAP_COUNT - 1) : tap_idx - 1'b1;
          if (tap_idx == TAP_IDX_BITS'(1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          if (load_result) begin
            state                  <= ST_IDLE;
            result_valid           <= 1'b1;
            result.filtered_ac_red <= red_y;
            result.passed_dc_red   <= dc_red;
            result.filtered_ac_ir  <= ir_y;
            result.passed_dc_ir    <= dc_ir;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/fir_ldc_checker.sv */
module fir_ldc_checker import fir_ldc_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         sample_valid,
  input logic         sample_ready,
  input logic         result_valid,
  input logic         result_ready,
  input result_word_t result
);

  logic [2:0] outstanding;

  // Words accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(sample_valid && sample_ready)
                     - 3'(result_valid && result_ready);
    end
  end

  // A result word is never withdrawn or altered before it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // The filter works on one word at a time after taking it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("sample taken while the filter is busy");

  // At most one word in the filter and one in the output register.
  a_in_flight: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'd2)
    else $error("too many words in flight");

  // No result word without an accepted sample word behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> outstanding != 3'd0)
    else $error("result word without a sample word");

endmodule

bind fir_lowpass_dual_channel_unit fir_ldc_checker u_fir_ldc_checker (.*);

/* tb/fir_lowpass_dual_channel_unit_tb.sv */
module fir_lowpass_dual_channel_unit_tb;
  import fir_ldc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Filter geometry as the predictor sees it.
  localparam int LP_TAPS = 51;
  localparam int LP_FRAC = 15;
  localparam int LP_HALF_TAPS = 26;
  localparam longint LP_MAX = 32767;
  localparam longint LP_MIN = -32768;

  // First half of the symmetric low-pass response in Q15; the taps sum to 1.0.
  localparam int LP_HALF_COEF [LP_HALF_TAPS] = '{
    0, 5, 13, 23, 39, 61, 91, 131, 180, 240, 312, 393, 485,
    585, 691, 801, 914, 1025, 1133, 1234, 1325, 1403, 1467, 1514, 1543, 1552
  };

  // Stretch of cycles in which neither side idles.
  localparam int STEADY_FROM = 20000;
  localparam int STEADY_TO   = 40000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         sample_valid = 1'b0;
  logic         sample_ready;
  sample_word_t sample = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_word_t result;

  sample_word_t sample_backlog [$];
  result_word_t expected_results [$];
  logic         word_taken = 1'b0;
  int           cycle_count = 0;
  int           mismatch_count = 0;
  logic         steady;

  // Predictor state: the two delay lines and the slot for the next sample.
  logic signed [SAMPLE_BITS-1:0] red_delay [LP_TAPS];
  logic signed [SAMPLE_BITS-1:0] ir_delay [LP_TAPS];
  int                            next_slot;

  fir_lowpass_dual_channel_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  assign steady = (cycle_count >= STEADY_FROM) && (cycle_count < STEADY_TO);

  // Rounds a Q15 sum half up and clamps it to the signed sample range.
  function automatic logic signed [SAMPLE_BITS-1:0] round_saturate(input longint acc);
    longint y;
    y = (acc + (longint'(1) <<< (LP_FRAC - 1))) >>> LP_FRAC;
    if (y > LP_MAX) begin
      y = LP_MAX;
    end
    if (y < LP_MIN) begin
      y = LP_MIN;
    end
    return y[SAMPLE_BITS-1:0];
  endfunction

  // Writes one sample set into the delay lines and forms both filter outputs.
  function automatic result_word_t lowpass_predict(input sample_word_t w);
    result_word_t r;
    longint       acc_red;
    longint       acc_ir;
    longint       weight;
    int           slot;
    red_delay[next_slot] = w.ac_red;
    ir_delay[next_slot]  = w.ac_ir;
    acc_red = 0;
    acc_ir  = 0;
    slot    = next_slot;
    // The newest sample meets the first tap, then walk backward in time.
    for (int k = 0; k < LP_TAPS; k++) begin
      weight  = (k < LP_HALF_TAPS) ? LP_HALF_COEF[k] : LP_HALF_COEF[LP_TAPS - 1 - k];
      acc_red += weight * longint'(red_delay[slot]);
      acc_ir  += weight * longint'(ir_delay[slot]);
      slot    = (slot == 0) ? LP_TAPS - 1 : slot - 1;
    end
    next_slot = (next_slot + 1 >= LP_TAPS) ? 0 : next_slot + 1;
    r.filtered_ac_red = round_saturate(acc_red);
    r.passed_dc_red   = w.dc_red;
    r.filtered_ac_ir  = round_saturate(acc_ir);
    r.passed_dc_ir    = w.dc_ir;
    return r;
  endfunction

  task automatic queue_word(input logic [15:0] ac_r, input logic [15:0] dc_r,
                            input logic [15:0] ac_i, input logic [15:0] dc_i);
    sample_word_t w;
    w.ac_red = ac_r;
    w.dc_red = dc_r;
    w.ac_ir  = ac_i;
    w.dc_ir  = dc_i;
    sample_backlog.push_back(w);
  endtask

  // Driver: present the next word at the falling edge and hold it until taken.
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      result_ready <= steady || ($urandom_range(99) >= 8);
      if (!sample_valid || word_taken) begin
        if (sample_backlog.size() > 0 && (steady || $urandom_range(99) >= 8)) begin
          sample       <= sample_backlog.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each accepted sample word and check each result word.
  always @(posedge clk) begin
    result_word_t want;
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      word_taken  <= sample_valid && sample_ready;
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word arrived with none expected");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.filtered_ac_red !== want.filtered_ac_red) begin
            $error("filtered_ac_red: expected %0d, got %0d",
                   want.filtered_ac_red, result.filtered_ac_red);
            mismatch_count++;
          end
          if (result.passed_dc_red !== want.passed_dc_red) begin
            $error("passed_dc_red: expected %0d, got %0d",
                   want.passed_dc_red, result.passed_dc_red);
            mismatch_count++;
          end
          if (result.filtered_ac_ir !== want.filtered_ac_ir) begin
            $error("filtered_ac_ir: expected %0d, got %0d",
                   want.filtered_ac_ir, result.filtered_ac_ir);
            mismatch_count++;
          end
          if (result.passed_dc_ir !== want.passed_dc_ir) begin
            $error("passed_dc_ir: expected %0d, got %0d",
                   want.passed_dc_ir, result.passed_dc_ir);
            mismatch_count++;
          end
        end
      end
      if (sample_valid && sample_ready) begin
        expected_results.push_back(lowpass_predict(sample));
      end
    end
  end

  initial begin
    int          mode;
    int          run_len;
    logic [15:0] amp_r;
    logic [15:0] amp_i;

    for (int i = 0; i < LP_TAPS; i++) begin
      red_delay[i] = '0;
      ir_delay[i]  = '0;
    end
    next_slot = 0;

    // Directed words: opposite extremes on the two channels from a zero history,
    // then bit patterns, unit values and zeros that walk the first responses out.
    queue_word(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF);
    queue_word(16'h0000, 16'hAAAA, 16'h0000, 16'h5555);
    queue_word(16'h0000, 16'h5555, 16'h0000, 16'hAAAA);
    queue_word(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000);
    queue_word(16'h0001, 16'h0001, 16'hFFFF, 16'h8000);
    queue_word(16'hFFFF, 16'h8000, 16'h0001, 16'h0001);
    queue_word(16'h5555, 16'h7FFF, 16'hAAAA, 16'h0000);
    queue_word(16'hAAAA, 16'h0000, 16'h5555, 16'h7FFF);
    for (int i = 0; i < 12; i++) begin
      queue_word(16'h0000, 16'($urandom), 16'h0000, 16'($urandom));
    end

    // Random part: runs of one signal shape each, so steady states are reached.
    while (sample_backlog.size() < 1720) begin
      mode    = $urandom_range(5);
      run_len = $urandom_range(20, 80);
      amp_r   = 16'($urandom);
      amp_i   = 16'($urandom);
      for (int i = 0; i < run_len; i++) begin
        case (mode)
          0: queue_word(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          1: queue_word($urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom),
                        $urandom_range(1) ? 16'h7FFF : 16'h8000, 16'($urandom));
          2: queue_word(16'(int'($urandom_range(510)) - 255), 16'($urandom),
                        16'(int'($urandom_range(510)) - 255), 16'($urandom));
          // Full-scale alternation sits at the top of the stop band.
          3: queue_word(16'h7FFF ^ {16{i[0]}}, 16'($urandom),
                        16'h8000 ^ {16{i[0]}}, 16'($urandom));
          4: queue_word(amp_r, 16'($urandom), amp_i, 16'($urandom));
          default: queue_word(($urandom_range(9) == 0) ? 16'($urandom) : 16'h0000,
                              16'($urandom),
                              ($urandom_range(9) == 0) ? 16'($urandom) : 16'h0000,
                              16'($urandom));
        endcase
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Drain: every word sent and every result word back, then a latency's margin.
    while (sample_backlog.size() != 0 || sample_valid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (60) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
